FILE: rtl/tfc_pkg.sv
// Shared types, constants and saturating helpers for the track frame
// compensation pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

    localparam int QW       = 32;
    localparam int PW       = 64;
    localparam int SW       = 65;
    localparam int NUM_PAIR = 4;
    localparam int NUM_MUL  = 4 * NUM_PAIR;
    localparam int NUM_ROT  = 2 * NUM_PAIR;
    localparam int RW       = 34;
    localparam int YW       = 48;
    localparam int ROT_SH   = 30;
    localparam int YAW_SH   = 16;
    localparam int TDATA_W  = 11 * QW;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS_HEADING        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_HEADING        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_POSITION     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_HEADING      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_VELOCITY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_ACCELERATION = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_TURN_RATE    = 3'd7;

    localparam logic signed [QW-1:0] TRIG_ONE     = 32'sh4000_0000;
    localparam logic signed [QW-1:0] TRIG_NEG_ONE = 32'shC000_0000;
    localparam logic signed [SW-1:0] RND_ROT      = 65'sd536870912;
    localparam logic signed [SW-1:0] RND_YAW      = 65'sd32768;

    // first field sits in the highest bits
    typedef struct packed {
        logic signed [QW-1:0] meas_heading;
        logic signed [QW-1:0] meas_y;
        logic signed [QW-1:0] meas_x;
        logic signed [QW-1:0] turn_rate;
        logic signed [QW-1:0] acc_y;
        logic signed [QW-1:0] acc_x;
        logic signed [QW-1:0] vel_y;
        logic signed [QW-1:0] vel_x;
        logic signed [QW-1:0] heading;
        logic signed [QW-1:0] pos_y;
        logic signed [QW-1:0] pos_x;
    } track_t;

    typedef struct packed {
        logic                 global_mode;
        logic signed [QW-1:0] cos_heading;
        logic signed [QW-1:0] sin_heading;
        logic [PW-1:0]        lidar_position;
        logic signed [QW-1:0] lidar_heading;
        logic [PW-1:0]        lidar_velocity;
        logic [PW-1:0]        lidar_acceleration;
        logic signed [QW-1:0] lidar_turn_rate;
    } cfg_t;

    typedef logic [NUM_MUL-1:0][QW-1:0] opnd_t;
    typedef logic [NUM_MUL-1:0][PW-1:0] prod_t;
    typedef logic [NUM_ROT-1:0][RW-1:0] rot_t;

    typedef struct packed {
        logic   track_valid;
        logic   global_mode;
        track_t trk;
        opnd_t  op_a;
        opnd_t  op_b;
    } s1_t;

    typedef struct packed {
        logic   track_valid;
        logic   global_mode;
        track_t trk;
        prod_t  prod;
    } s2_t;

    typedef struct packed {
        logic                 track_valid;
        logic                 global_mode;
        track_t               trk;
        rot_t                 rot;
        logic signed [YW-1:0] add_x;
        logic signed [YW-1:0] add_y;
    } s3_t;

    function automatic logic signed [PW-1:0] ext_q(input logic [QW-1:0] v);
        return $signed({{(PW-QW){v[QW-1]}}, v});
    endfunction

    function automatic logic signed [PW-1:0] ext_r(input logic [RW-1:0] v);
        return $signed({{(PW-RW){v[RW-1]}}, v});
    endfunction

    function automatic logic signed [PW-1:0] ext_y(input logic [YW-1:0] v);
        return $signed({{(PW-YW){v[YW-1]}}, v});
    endfunction

    function automatic logic signed [QW-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = ext_q(32'h7FFF_FFFF);
        lo = ext_q(32'h8000_0000);
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[QW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] add_sat(input logic [QW-1:0] a,
                                                     input logic [QW-1:0] b);
        return sat32(ext_q(a) + ext_q(b));
    endfunction

    function automatic logic signed [QW-1:0] sub_sat(input logic [QW-1:0] a,
                                                     input logic [QW-1:0] b);
        return sat32(ext_q(a) - ext_q(b));
    endfunction

    function automatic logic signed [QW-1:0] trig_clamp(input logic signed [QW-1:0] t);
        if (t > TRIG_ONE)
        begin
            return TRIG_ONE;
        end
        if (t < TRIG_NEG_ONE)
        begin
            return TRIG_NEG_ONE;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tfc_front.sv
// First pipeline stage: clamps trig terms, forms relative positions and heading
// and yaw-rate sums, and steers multiplier operands. Depends on tfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            in_track_valid,
    input  wire tfc_pkg::track_t in_trk,
    input  wire tfc_pkg::cfg_t   cfg,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tfc_pkg::s1_t         out
);
    import tfc_pkg::*;

    logic                 valid_reg;
    s1_t                  data_reg;
    s1_t                  data_next;
    logic signed [QW-1:0] c;
    logic signed [QW-1:0] s;
    logic signed [QW-1:0] pa [NUM_PAIR];
    logic signed [QW-1:0] pb [NUM_PAIR];
    logic                 act;

    always_comb
    begin
        c   = trig_clamp(cfg.cos_heading);
        s   = trig_clamp(cfg.sin_heading);
        act = in_track_valid;

        data_next             = '0;
        data_next.track_valid = in_track_valid;
        data_next.global_mode = cfg.global_mode;
        data_next.trk         = in_trk;

        if (cfg.global_mode)
        begin
            pa[0] = in_trk.vel_x;
            pb[0] = in_trk.vel_y;
            pa[1] = in_trk.acc_x;
            pb[1] = in_trk.acc_y;
            pa[2] = sub_sat(in_trk.pos_x, cfg.lidar_position[QW-1:0]);
            pb[2] = sub_sat(in_trk.pos_y, cfg.lidar_position[PW-1:QW]);
            pa[3] = sub_sat(in_trk.meas_x, cfg.lidar_position[QW-1:0]);
            pb[3] = sub_sat(in_trk.meas_y, cfg.lidar_position[PW-1:QW]);
            if (act)
            begin
                data_next.trk.heading      = sub_sat(in_trk.heading, cfg.lidar_heading);
                data_next.trk.meas_heading = sub_sat(in_trk.meas_heading, cfg.lidar_heading);
            end
        end
        else
        begin
            pa[0] = cfg.lidar_velocity[QW-1:0];
            pb[0] = cfg.lidar_velocity[PW-1:QW];
            pa[1] = cfg.lidar_acceleration[QW-1:0];
            pb[1] = cfg.lidar_acceleration[PW-1:QW];
            pa[2] = '0;
            pb[2] = '0;
            pa[3] = '0;
            pb[3] = '0;
            if (act)
            begin
                data_next.trk.turn_rate = add_sat(in_trk.turn_rate, cfg.lidar_turn_rate);
            end
        end

        for (int k = 0; k < NUM_PAIR; k++)
        begin
            data_next.op_a[4*k]   = c;
            data_next.op_b[4*k]   = pa[k];
            data_next.op_a[4*k+1] = s;
            data_next.op_b[4*k+1] = pb[k];
            data_next.op_a[4*k+2] = s;
            data_next.op_b[4*k+2] = pa[k];
            data_next.op_a[4*k+3] = c;
            data_next.op_b[4*k+3] = pb[k];
        end

        // local mode: yaw-rate terms use the position slot
        if (!cfg.global_mode)
        begin
            data_next.op_a[8] = cfg.lidar_turn_rate;
            data_next.op_b[8] = in_trk.pos_y;
            data_next.op_a[9] = cfg.lidar_turn_rate;
            data_next.op_b[9] = in_trk.pos_x;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tfc_mul.sv
// Multiplier stage: sixteen registered 32x32 signed products.
// Depends on tfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfc_mul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tfc_pkg::s1_t  in,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tfc_pkg::s2_t       out
);
    import tfc_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    always_comb
    begin
        data_next.track_valid = in.track_valid;
        data_next.global_mode = in.global_mode;
        data_next.trk         = in.trk;
        for (int k = 0; k < NUM_MUL; k++)
        begin
            data_next.prod[k] = ext_q(in.op_a[k]) * ext_q(in.op_b[k]);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tfc_back.sv
// Back stages: rounds product sums to Q16.16, then adds and saturates into
// the output register. Depends on tfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tfc_pkg::s2_t    in,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 out_track_valid,
    output tfc_pkg::track_t      out_trk
);
    import tfc_pkg::*;

    logic                 rnd_valid_reg;
    s3_t                  rnd_reg;
    s3_t                  rnd_next;
    logic                 rnd_ready;
    logic                 res_valid_reg;
    logic                 res_tv_reg;
    track_t               res_reg;
    track_t               res_next;
    logic signed [SW-1:0] sum_a;
    logic signed [SW-1:0] sum_b;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;

    always_comb
    begin
        rnd_next.track_valid = in.track_valid;
        rnd_next.global_mode = in.global_mode;
        rnd_next.trk         = in.trk;
        sum_a                = '0;
        sum_b                = '0;
        for (int k = 0; k < NUM_PAIR; k++)
        begin
            sum_a = $signed({in.prod[4*k][PW-1], in.prod[4*k]})
                  + $signed({in.prod[4*k+1][PW-1], in.prod[4*k+1]}) + RND_ROT;
            sum_b = $signed({in.prod[4*k+3][PW-1], in.prod[4*k+3]})
                  - $signed({in.prod[4*k+2][PW-1], in.prod[4*k+2]}) + RND_ROT;
            rnd_next.rot[2*k]   = sum_a[ROT_SH+RW-1:ROT_SH];
            rnd_next.rot[2*k+1] = sum_b[ROT_SH+RW-1:ROT_SH];
        end
        sum_x = RND_YAW - $signed({in.prod[8][PW-1], in.prod[8]});
        sum_y = $signed({in.prod[9][PW-1], in.prod[9]}) + RND_YAW;
        rnd_next.add_x = sum_x[YAW_SH+YW-1:YAW_SH];
        rnd_next.add_y = sum_y[YAW_SH+YW-1:YAW_SH];
    end

    always_comb
    begin
        res_next = rnd_reg.trk;
        if (rnd_reg.track_valid)
        begin
            if (rnd_reg.global_mode)
            begin
                res_next.vel_x  = sat32(ext_r(rnd_reg.rot[0]));
                res_next.vel_y  = sat32(ext_r(rnd_reg.rot[1]));
                res_next.acc_x  = sat32(ext_r(rnd_reg.rot[2]));
                res_next.acc_y  = sat32(ext_r(rnd_reg.rot[3]));
                res_next.pos_x  = sat32(ext_r(rnd_reg.rot[4]));
                res_next.pos_y  = sat32(ext_r(rnd_reg.rot[5]));
                res_next.meas_x = sat32(ext_r(rnd_reg.rot[6]));
                res_next.meas_y = sat32(ext_r(rnd_reg.rot[7]));
            end
            else
            begin
                res_next.vel_x = sat32(ext_q(rnd_reg.trk.vel_x) + ext_r(rnd_reg.rot[0])
                                       + ext_y(rnd_reg.add_x));
                res_next.vel_y = sat32(ext_q(rnd_reg.trk.vel_y) + ext_r(rnd_reg.rot[1])
                                       + ext_y(rnd_reg.add_y));
                res_next.acc_x = sat32(ext_q(rnd_reg.trk.acc_x) + ext_r(rnd_reg.rot[2]));
                res_next.acc_y = sat32(ext_q(rnd_reg.trk.acc_y) + ext_r(rnd_reg.rot[3]));
            end
        end
    end

    assign in_ready        = !rnd_valid_reg || rnd_ready;
    assign rnd_ready       = !res_valid_reg || out_ready;
    assign out_valid       = res_valid_reg;
    assign out_track_valid = res_tv_reg;
    assign out_trk         = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                rnd_valid_reg <= in_valid;
            end
            if (rnd_ready)
            begin
                res_valid_reg <= rnd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rnd_reg <= rnd_next;
        end
        if (rnd_ready && rnd_valid_reg)
        begin
            res_reg    <= res_next;
            res_tv_reg <= rnd_reg.track_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/track_frame_compensation.sv
// Top level of the track frame compensation block: configuration registers
// and the four-stage pipeline. Depends on tfc_pkg, tfc_front, tfc_mul, tfc_back.
`timescale 1ns / 1ps
`default_nettype none

// Re-expresses one track state per item relative to the sensor pose held in
// the configuration registers (global conversion or local motion compensation).
// The block takes one item per cycle while the master side accepts. Four
// register stages lie between the two sides: operand setup, sixteen 32x32
// multipliers, rounding of the product sums, then final sums with saturation
// into the output register, which presents each result on the master side.
// Each stage holds its item while the next one is full, so a stall on the
// output side fills the pipeline before the input side sees tready low.
// Write configuration only while no item is in flight.
module track_frame_compensation (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x, pos_y, heading, vel_x, vel_y, acc_x, acc_y, turn_rate,
    // meas_x, meas_y, meas_heading
    input  wire logic [tfc_pkg::TDATA_W-1:0]    s_axis_tdata,
    // track_valid
    input  wire logic [0:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_pos_x, out_pos_y, out_heading, out_vel_x, out_vel_y, out_acc_x,
    // out_acc_y, out_turn_rate, out_meas_x, out_meas_y, out_meas_heading
    output logic [tfc_pkg::TDATA_W-1:0]         m_axis_tdata,
    // out_valid_track
    output logic [0:0]                          m_axis_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [tfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tfc_pkg::*;

    cfg_t   cfg_reg;
    s1_t    s1;
    logic   s1_valid;
    logic   s1_ready;
    s2_t    s2;
    logic   s2_valid;
    logic   s2_ready;
    track_t out_trk;
    logic   out_tv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.global_mode        <= 1'b0;
            cfg_reg.cos_heading        <= TRIG_ONE;
            cfg_reg.sin_heading        <= '0;
            cfg_reg.lidar_position     <= '0;
            cfg_reg.lidar_heading      <= '0;
            cfg_reg.lidar_velocity     <= '0;
            cfg_reg.lidar_acceleration <= '0;
            cfg_reg.lidar_turn_rate    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GLOBAL_MODE:        cfg_reg.global_mode        <= cfg_data[0];
                REG_COS_HEADING:        cfg_reg.cos_heading        <= cfg_data[QW-1:0];
                REG_SIN_HEADING:        cfg_reg.sin_heading        <= cfg_data[QW-1:0];
                REG_LIDAR_POSITION:     cfg_reg.lidar_position     <= cfg_data;
                REG_LIDAR_HEADING:      cfg_reg.lidar_heading      <= cfg_data[QW-1:0];
                REG_LIDAR_VELOCITY:     cfg_reg.lidar_velocity     <= cfg_data;
                REG_LIDAR_ACCELERATION: cfg_reg.lidar_acceleration <= cfg_data;
                REG_LIDAR_TURN_RATE:    cfg_reg.lidar_turn_rate    <= cfg_data[QW-1:0];
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    tfc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_track_valid (s_axis_tuser[0]),
        .in_trk         (track_t'(s_axis_tdata)),
        .cfg            (cfg_reg),
        .out_valid      (s1_valid),
        .out_ready      (s1_ready),
        .out            (s1)
    );

    tfc_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in        (s1),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out       (s2)
    );

    tfc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s2_valid),
        .in_ready        (s2_ready),
        .in              (s2),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_track_valid (out_tv),
        .out_trk         (out_trk)
    );

    assign m_axis_tdata = out_trk;
    assign m_axis_tuser = out_tv;

endmodule

`default_nettype wire
